FILE: rtl/vlsf_pkg.sv
// Shared types, constants and fixed-point helpers for the Van Leer split flux block.
package vlsf_pkg;

  localparam int FRAC_BITS = 16;
  // Quotient bits kept by the dividers; anything larger saturates anyway.
  localparam int DIV_BITS  = 33;
  // Width of a divider numerator after scaling and rounding offset.
  localparam int NUM_W     = 33 + FRAC_BITS;
  // Width of the square root radicand and the number of digit steps.
  localparam int SQ_W      = 32 + FRAC_BITS;
  localparam int SQ_STEPS  = SQ_W / 2;
  localparam int PADDR_W   = 3;
  localparam int FLOOR_W   = 17;

  localparam logic IDX_FLOOR = 1'b0;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_ONE       = 32'(1 << FRAC_BITS);
  localparam q_t Q_HALF      = 32'(1 << (FRAC_BITS - 1));
  localparam q_t Q_QUARTER   = 32'(1 << (FRAC_BITS - 2));
  localparam q_t Q_GAMMA     = 32'(((14 << FRAC_BITS) + 5) / 10);
  localparam q_t Q_GM1       = 32'(((4 << FRAC_BITS) + 5) / 10);
  localparam q_t Q_INV_GAMMA = 32'(((5 << FRAC_BITS) + 3) / 7);
  localparam q_t Q_ENTH      = 32'(((25 << FRAC_BITS) + 24) / 48);
  localparam q_t S_MAX       = 32'sh7fffffff;
  localparam q_t S_MIN       = 32'sh80000000;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FLOORED,
    ST_ZERO_RHO
  } status_e;

  typedef struct packed {
    logic valid;
    logic last;
    logic zden;
  } tag_t;

  // Per-side context; the scratch fields are reused from stage to stage.
  typedef struct packed {
    tag_t tag;
    q_t   rho;
    q_t   mn;
    q_t   mt;
    q_t   en;
    q_t   u;
    q_t   v;
    q_t   p;
    q_t   a;
    q_t   h;
    q_t   m;
    q_t   x1;
    q_t   x2;
    q_t   x3;
    q_t   x4;
    q_t   x5;
    q_t   x6;
    q_t   x7;
    q_t   x8;
    logic fl;
    logic full;
    logic none;
  } side_t;

  typedef struct packed {
    tag_t       tag;
    logic       fl;
    q_t [3:0]   f;
  } side_out_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    status_e    status;
    q_t [3:0]   flux;
  } res_t;

  typedef struct packed {
    logic                zero;
    logic                apos;
    logic                aneg;
    logic                neg;
    logic                over;
    logic [31:0]         d;
    logic [31:0]         r;
    logic [DIV_BITS-1:0] nlo;
    logic [DIV_BITS-1:0] q;
  } div_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] res;
  } sq_t;

  function automatic q_t sat_wide(input logic signed [33:0] x);
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      return x[31:0];
    end
    return x[33] ? S_MIN : S_MAX;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [33:0] s;
    s = $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b});
    return sat_wide(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [33:0] s;
    s = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
    return sat_wide(s);
  endfunction

  function automatic q_t qneg(input q_t a);
    logic signed [33:0] s;
    s = -$signed({{2{a[31]}}, a});
    return sat_wide(s);
  endfunction

  // Apply a sign to a magnitude and saturate to 32 bits.
  function automatic q_t smag(input logic neg, input logic [63:0] mag);
    logic [31:0] lo;
    lo = mag[31:0];
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) return S_MIN;
      return $signed(~lo + 32'd1);
    end
    if (mag > 64'h0000_0000_7fff_ffff) return S_MAX;
    return $signed(lo);
  endfunction

  // Fixed-point product, magnitude rounded half away from zero.
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] pr;
    logic [63:0]        mag;
    pr  = 64'(a) * 64'(b);
    mag = pr[63] ? (~pr + 64'd1) : pr;
    mag = (mag + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return smag(pr[63], mag);
  endfunction

  function automatic div_t div_init(input q_t a, input q_t b);
    div_t             s;
    logic [31:0]      ua;
    logic [31:0]      ub;
    logic [NUM_W-1:0] nn;
    logic [NUM_W-1:0] hi;
    ua     = a[31] ? (~a + 32'd1) : a;
    ub     = b[31] ? (~b + 32'd1) : b;
    nn     = (NUM_W'(ua) << FRAC_BITS) + NUM_W'(ub >> 1);
    hi     = nn >> DIV_BITS;
    s.zero = (b == '0);
    s.apos = !a[31] && (a != '0);
    s.aneg = a[31];
    s.neg  = a[31] ^ b[31];
    s.over = (hi >= NUM_W'(ub));
    s.d    = ub;
    s.r    = hi[31:0];
    s.nlo  = nn[DIV_BITS-1:0];
    s.q    = '0;
    return s;
  endfunction

  // One restoring step that settles quotient bit i.
  function automatic div_t div_step(input div_t s, input int i);
    div_t        o;
    logic [32:0] rr;
    o  = s;
    rr = {s.r, s.nlo[i]};
    if (rr >= {1'b0, s.d}) begin
      rr     = rr - {1'b0, s.d};
      o.q[i] = 1'b1;
    end
    o.r = rr[31:0];
    return o;
  endfunction

  function automatic q_t div_fin(input div_t s);
    logic [63:0] mag;
    mag = s.over ? (64'd1 << DIV_BITS) : 64'(s.q);
    if (s.zero) begin
      if (s.apos) return S_MAX;
      if (s.aneg) return S_MIN;
      return '0;
    end
    return smag(s.neg, mag);
  endfunction

  function automatic sq_t sq_init(input q_t x);
    sq_t s;
    s.res = '0;
    if (x[31] || x == '0) begin
      s.n = '0;
    end else begin
      s.n = SQ_W'(x[30:0]) << FRAC_BITS;
    end
    return s;
  endfunction

  // One digit of the integer square root, starting from the top even bit.
  function automatic sq_t sq_step(input sq_t s, input int k);
    sq_t             o;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] t;
    bitv = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    t    = s.res + bitv;
    if (s.n >= t) begin
      o.n   = s.n - t;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.n   = s.n;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage

FILE: rtl/van_leer_split_flux.sv
// Top level of the Van Leer flux vector splitting kernel for 2D Euler cell faces.
// This block takes one cell face per request, carrying the left and right conserved
// states in signed Q16.16, and returns the face flux F+(left) + F-(right) for gamma 1.4,
// each component saturated to 32 bits. The face axis picks which momentum is normal.
// The whole path is a fixed pipeline: a new face can be accepted in every clock cycle
// in which the skid entry is empty. Most of the pipeline is taken up by the three
// chained divider sections of each side (velocities, then sound speed argument and
// enthalpy, then Mach number, five restoring dividers in all) and the square root,
// which resolve one quotient or root bit per stage. A stall on the result
// side is absorbed by a one-entry
// skid register behind the output register, so the input only stops while that skid
// entry is occupied; results are never dropped or repeated. The pressure floor is
// written through the APB port at byte address 0 and must only change while no
// faces are in flight. A face with a zero density yields all-zero fluxes and status 2;
// otherwise status 1 means one of the two pressures was raised to the floor.
module van_leer_split_flux
  import vlsf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Face requests.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata from bit 0: rho_left[31], mom_x_left[32], mom_y_left[32], energy_left[31],
  // rho_right[31], mom_x_right[32], mom_y_right[32], energy_right[31], zero pad[4].
  input  logic [255:0]       s_axis_tdata,
  // tuser: face_axis.
  input  logic [0:0]         s_axis_tuser,
  input  logic               s_axis_tlast,
  // Flux results.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata from bit 0: flux_mass, flux_normal_mom, flux_tangent_mom, flux_energy.
  output logic [127:0]       m_axis_tdata,
  // tuser: status.
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  logic [FLOOR_W-1:0] floor_q;
  logic               en;
  side_t              in_l;
  side_t              in_r;
  side_out_t          out_l;
  side_out_t          out_r;
  res_t               res_d;
  res_t               res_q;
  res_t               out_q;
  res_t               skid_q;
  logic               zden;
  q_t                 mxl;
  q_t                 myl;
  q_t                 mxr;
  q_t                 myr;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == IDX_FLOOR) begin
      floor_q <= pwdata[FLOOR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == IDX_FLOOR) ? {{(32 - FLOOR_W){1'b0}}, floor_q} : '0;

  // The whole pipeline advances together unless the skid entry holds a result.
  assign en            = !skid_q.valid;
  assign s_axis_tready = en;

  assign mxl  = $signed(s_axis_tdata[62:31]);
  assign myl  = $signed(s_axis_tdata[94:63]);
  assign mxr  = $signed(s_axis_tdata[188:157]);
  assign myr  = $signed(s_axis_tdata[220:189]);
  assign zden = (s_axis_tdata[30:0] == '0) || (s_axis_tdata[156:126] == '0);

  // The face axis swaps which momentum is treated as normal.
  always_comb begin
    in_l           = '0;
    in_l.tag.valid = s_axis_tvalid;
    in_l.tag.last  = s_axis_tlast;
    in_l.tag.zden  = zden;
    in_l.rho       = $signed({1'b0, s_axis_tdata[30:0]});
    in_l.en        = $signed({1'b0, s_axis_tdata[125:95]});
    in_l.mn        = s_axis_tuser[0] ? myl : mxl;
    in_l.mt        = s_axis_tuser[0] ? mxl : myl;

    in_r           = in_l;
    in_r.rho       = $signed({1'b0, s_axis_tdata[156:126]});
    in_r.en        = $signed({1'b0, s_axis_tdata[251:221]});
    in_r.mn        = s_axis_tuser[0] ? myr : mxr;
    in_r.mt        = s_axis_tuser[0] ? mxr : myr;
  end

  vlsf_side u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .backward_i (1'b0),
    .floor_i    (floor_q),
    .in_i       (in_l),
    .out_o      (out_l)
  );

  vlsf_side u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .backward_i (1'b1),
    .floor_i    (floor_q),
    .in_i       (in_r),
    .out_o      (out_r)
  );

  // Sum the two split fluxes; a zero density overrides everything.
  always_comb begin
    res_d.valid = out_l.tag.valid & out_r.tag.valid;
    res_d.last  = out_l.tag.last;
    for (int i = 0; i < 4; i++) begin
      res_d.flux[i] = out_l.tag.zden ? '0 : qadd(out_l.f[i], out_r.f[i]);
    end
    if (out_l.tag.zden) begin
      res_d.status = ST_ZERO_RHO;
    end else if (out_l.fl || out_r.fl) begin
      res_d.status = ST_FLOORED;
    end else begin
      res_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (en) begin
      res_q <= res_d;
    end
  end

  // Output register plus skid entry. When the pipeline moves and the output is
  // blocked, the result leaving the pipeline parks in the skid entry; the pipeline
  // then holds until the skid entry drains into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else if (en) begin
      if (out_q.valid && !m_axis_tready) begin
        if (res_q.valid) begin
          skid_q <= res_q;
        end
      end else begin
        out_q <= res_q;
      end
    end else if (!out_q.valid || m_axis_tready) begin
      out_q        <= skid_q;
      skid_q.valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_q.valid;
  assign m_axis_tdata  = out_q.flux;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule

FILE: rtl/vlsf_side.sv
// Pipelined evaluation of one face side: primitive variables and its split flux.
module vlsf_side
  import vlsf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               backward_i,
  input  logic [FLOOR_W-1:0] floor_i,
  input  side_t              in_i,
  output side_out_t          out_o
);

  side_t     s0_q;
  side_t     ca_q [DIV_BITS+1];
  div_t      da_q [2][DIV_BITS+1];
  side_t     m_d  [6];
  side_t     m_q  [6];
  side_t     cb_q [DIV_BITS+1];
  div_t      db_q [2][DIV_BITS+1];
  side_t     cs_q [SQ_STEPS+1];
  sq_t       sq_q [SQ_STEPS+1];
  side_t     cc_q [DIV_BITS+1];
  div_t      dc_q [DIV_BITS+1];
  side_t     p_d  [7];
  side_t     p_q  [7];
  side_out_t out_d;
  side_out_t out_q;
  side_t     cs0_d;
  side_t     cc0_d;
  q_t        a_root;
  q_t        floor_q;

  assign floor_q = $signed({{(32 - FLOOR_W){1'b0}}, floor_i});
  assign a_root  = $signed(sq_q[SQ_STEPS].res[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (en_i) begin
      s0_q <= in_i;
    end
  end

  // Velocities u and v: two dividers side by side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q[0] <= '0;
    end else if (en_i) begin
      ca_q[0] <= s0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      da_q[0][0] <= div_init(s0_q.mn, s0_q.rho);
      da_q[1][0] <= div_init(s0_q.mt, s0_q.rho);
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div_a
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ca_q[k] <= '0;
      end else if (en_i) begin
        ca_q[k] <= ca_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        da_q[0][k] <= div_step(da_q[0][k-1], DIV_BITS - k);
        da_q[1][k] <= div_step(da_q[1][k-1], DIV_BITS - k);
      end
    end
  end

  // Kinetic energy, pressure with floor, and the operands of the next divides.
  always_comb begin
    m_d[0]    = ca_q[DIV_BITS];
    m_d[0].u  = div_fin(da_q[0][DIV_BITS]);
    m_d[0].v  = div_fin(da_q[1][DIV_BITS]);

    m_d[1]    = m_q[0];
    m_d[1].x1 = qmul(m_q[0].mn, m_q[0].u);
    m_d[1].x2 = qmul(m_q[0].mt, m_q[0].v);

    m_d[2]    = m_q[1];
    m_d[2].x1 = qmul(Q_HALF, qadd(m_q[1].x1, m_q[1].x2));

    m_d[3]    = m_q[2];
    m_d[3].x1 = qmul(Q_GM1, qsub(m_q[2].en, m_q[2].x1));

    m_d[4]    = m_q[3];
    m_d[4].fl = (m_q[3].x1 < floor_q);
    m_d[4].p  = (m_q[3].x1 < floor_q) ? floor_q : m_q[3].x1;

    m_d[5]    = m_q[4];
    m_d[5].x1 = qmul(Q_GAMMA, m_q[4].p);
    m_d[5].x2 = qadd(m_q[4].en, m_q[4].p);
  end

  for (genvar k = 0; k < 6; k++) begin : g_mid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_q[k] <= '0;
      end else if (en_i) begin
        m_q[k] <= m_d[k];
      end
    end
  end

  // gamma*p/rho for the sound speed, and enthalpy (E+p)/rho.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q[0] <= '0;
    end else if (en_i) begin
      cb_q[0] <= m_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      db_q[0][0] <= div_init(m_q[5].x1, m_q[5].rho);
      db_q[1][0] <= div_init(m_q[5].x2, m_q[5].rho);
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div_b
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cb_q[k] <= '0;
      end else if (en_i) begin
        cb_q[k] <= cb_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        db_q[0][k] <= div_step(db_q[0][k-1], DIV_BITS - k);
        db_q[1][k] <= div_step(db_q[1][k-1], DIV_BITS - k);
      end
    end
  end

  // Sound speed by digit-recurrence square root.
  always_comb begin
    cs0_d   = cb_q[DIV_BITS];
    cs0_d.h = div_fin(db_q[1][DIV_BITS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q[0] <= '0;
    end else if (en_i) begin
      cs_q[0] <= cs0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0] <= sq_init(div_fin(db_q[0][DIV_BITS]));
    end
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cs_q[k] <= '0;
      end else if (en_i) begin
        cs_q[k] <= cs_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k] <= sq_step(sq_q[k-1], k - 1);
      end
    end
  end

  // Mach number u/a.
  always_comb begin
    cc0_d   = cs_q[SQ_STEPS];
    cc0_d.a = a_root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q[0] <= '0;
    end else if (en_i) begin
      cc_q[0] <= cc0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dc_q[0] <= div_init(cs_q[SQ_STEPS].u, a_root);
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div_c
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cc_q[k] <= '0;
      end else if (en_i) begin
        cc_q[k] <= cc_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dc_q[k] <= div_step(dc_q[k-1], DIV_BITS - k);
      end
    end
  end

  // Split flux. The forward split uses M+1 and +2a, the backward one M-1 and -2a.
  always_comb begin
    p_d[0]      = cc_q[DIV_BITS];
    p_d[0].m    = div_fin(dc_q[DIV_BITS]);

    p_d[1]      = p_q[0];
    p_d[1].x1   = backward_i ? qsub(p_q[0].m, Q_ONE) : qadd(p_q[0].m, Q_ONE);
    p_d[1].x2   = qmul(Q_QUARTER, p_q[0].rho);
    p_d[1].x3   = qmul(Q_GM1, p_q[0].u);
    p_d[1].x4   = backward_i ? qneg(qadd(p_q[0].a, p_q[0].a)) : qadd(p_q[0].a, p_q[0].a);
    p_d[1].x5   = qmul(p_q[0].mn, p_q[0].u);
    p_d[1].x6   = qmul(p_q[0].mn, p_q[0].v);
    p_d[1].x7   = qmul(p_q[0].mn, p_q[0].h);
    p_d[1].x8   = qmul(p_q[0].v, p_q[0].v);
    p_d[1].full = backward_i ? (p_q[0].m < -Q_ONE) : (p_q[0].m > Q_ONE);
    p_d[1].none = backward_i ? (p_q[0].m > Q_ONE) : (p_q[0].m < -Q_ONE);

    p_d[2]      = p_q[1];
    p_d[2].x2   = qmul(p_q[1].x2, p_q[1].a);
    p_d[2].x1   = qmul(p_q[1].x1, p_q[1].x1);
    p_d[2].x3   = qadd(p_q[1].x3, p_q[1].x4);
    p_d[2].x5   = qadd(p_q[1].x5, p_q[1].p);
    p_d[2].x8   = qmul(Q_HALF, p_q[1].x8);

    p_d[3]      = p_q[2];
    p_d[3].x1   = backward_i ? qneg(qmul(p_q[2].x2, p_q[2].x1)) : qmul(p_q[2].x2, p_q[2].x1);
    p_d[3].x2   = qmul(p_q[2].x3, Q_INV_GAMMA);
    p_d[3].x4   = qmul(p_q[2].x3, p_q[2].x3);

    p_d[4]      = p_q[3];
    p_d[4].x2   = qmul(p_q[3].x1, p_q[3].x2);
    p_d[4].x3   = qmul(p_q[3].x1, p_q[3].v);
    p_d[4].x4   = qmul(p_q[3].x4, Q_ENTH);

    p_d[5]      = p_q[4];
    p_d[5].x4   = qadd(p_q[4].x4, p_q[4].x8);

    p_d[6]      = p_q[5];
    p_d[6].x4   = qmul(p_q[5].x1, p_q[5].x4);
  end

  for (genvar k = 0; k < 7; k++) begin : g_split
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        p_q[k] <= '0;
      end else if (en_i) begin
        p_q[k] <= p_d[k];
      end
    end
  end

  // Supersonic sides take the full flux or none of it.
  always_comb begin
    out_d.tag = p_q[6].tag;
    out_d.fl  = p_q[6].fl;
    if (p_q[6].full) begin
      out_d.f = {p_q[6].x7, p_q[6].x6, p_q[6].x5, p_q[6].mn};
    end else if (p_q[6].none) begin
      out_d.f = '0;
    end else begin
      out_d.f = {p_q[6].x4, p_q[6].x3, p_q[6].x2, p_q[6].x1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

FILE: rtl/vlsf_checker.sv
// Port-level assertions for the Van Leer split flux block and their binding.
module vlsf_checker
  import vlsf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [127:0]       m_axis_tdata,
  input logic [1:0]         m_axis_tuser,
  input logic               m_axis_tlast
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The input side only stops while a finished result is waiting.
  a_ready_only_on_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled without a pending result");

  // A zero density gives all-zero fluxes.
  a_zero_rho_flux: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_ZERO_RHO |-> m_axis_tdata == '0)
    else $error("nonzero flux with zero density status");

  // A floor write reads back on the next cycle.
  a_floor_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == IDX_FLOOR
      |=> paddr[2] != IDX_FLOOR
        || prdata == {{(32 - FLOOR_W){1'b0}}, $past(pwdata[FLOOR_W-1:0])})
    else $error("pressure floor readback mismatch");

endmodule

bind van_leer_split_flux vlsf_checker u_vlsf_checker (.*);
